// File: hdl/mav2fp_pkg.sv
package mav2fp_pkg;

    localparam logic [7:0] START_MARKER    = 8'hFD;
    localparam logic [7:0] SIGNATURE_BYTES = 8'd13;
    localparam logic [15:0] CRC_SEED       = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LEN     = 4'd1,
        PH_IFLAGS  = 4'd2,
        PH_CFLAGS  = 4'd3,
        PH_SEQ     = 4'd4,
        PH_SYS     = 4'd5,
        PH_COMP    = 4'd6,
        PH_MID0    = 4'd7,
        PH_MID1    = 4'd8,
        PH_MID2    = 4'd9,
        PH_PAYLOAD = 4'd10,
        PH_CRC_LO  = 4'd11,
        PH_CRC_HI  = 4'd12,
        PH_SIG     = 4'd13
    } phase_t;

    typedef struct packed {
        logic        frame_done;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  payload_length;
        logic [15:0] flag_bytes;
        logic [7:0]  sequence_number;
        logic [7:0]  system_id;
        logic [7:0]  component_id;
        logic [23:0] message_id;
        logic [15:0] crc_computed;
        logic [15:0] crc_received;
    } result_t;

    // crc-16/mcrf4xx, one byte
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'h0};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

// File: hdl/mav2fp_parser.sv
module mav2fp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    output mav2fp_pkg::result_t result
);

    mav2fp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  counter_reg, counter_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] flags_reg, flags_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic [7:0]  sysid_reg, sysid_next;
    logic [7:0]  compid_reg, compid_next;
    logic [23:0] msgid_reg, msgid_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [7:0]  counter_inc;
    logic [15:0] crc_upd;
    logic        done;
    logic        pvalid;

    assign counter_inc = counter_reg + 8'd1;
    assign crc_upd     = mav2fp_pkg::crc_add(crc_reg, data_byte);

    // next phase
    always_comb
    begin
        phase_next = mav2fp_pkg::PH_IDLE;
        unique case (phase_reg)
            mav2fp_pkg::PH_IDLE:
                phase_next = (data_byte == mav2fp_pkg::START_MARKER) ?
                             mav2fp_pkg::PH_LEN : mav2fp_pkg::PH_IDLE;
            mav2fp_pkg::PH_LEN:    phase_next = mav2fp_pkg::PH_IFLAGS;
            mav2fp_pkg::PH_IFLAGS: phase_next = mav2fp_pkg::PH_CFLAGS;
            mav2fp_pkg::PH_CFLAGS: phase_next = mav2fp_pkg::PH_SEQ;
            mav2fp_pkg::PH_SEQ:    phase_next = mav2fp_pkg::PH_SYS;
            mav2fp_pkg::PH_SYS:    phase_next = mav2fp_pkg::PH_COMP;
            mav2fp_pkg::PH_COMP:   phase_next = mav2fp_pkg::PH_MID0;
            mav2fp_pkg::PH_MID0:   phase_next = mav2fp_pkg::PH_MID1;
            mav2fp_pkg::PH_MID1:   phase_next = mav2fp_pkg::PH_MID2;
            mav2fp_pkg::PH_MID2:
                phase_next = (length_reg == 8'd0) ?
                             mav2fp_pkg::PH_CRC_LO : mav2fp_pkg::PH_PAYLOAD;
            mav2fp_pkg::PH_PAYLOAD:
                phase_next = (counter_inc >= length_reg) ?
                             mav2fp_pkg::PH_CRC_LO : mav2fp_pkg::PH_PAYLOAD;
            mav2fp_pkg::PH_CRC_LO: phase_next = mav2fp_pkg::PH_CRC_HI;
            mav2fp_pkg::PH_CRC_HI:
                phase_next = flags_reg[0] ? mav2fp_pkg::PH_SIG : mav2fp_pkg::PH_IDLE;
            mav2fp_pkg::PH_SIG:
                phase_next = (counter_inc >= mav2fp_pkg::SIGNATURE_BYTES) ?
                             mav2fp_pkg::PH_IDLE : mav2fp_pkg::PH_SIG;
            default:               phase_next = mav2fp_pkg::PH_IDLE;
        endcase
    end

    // captured fields and per-byte flags
    always_comb
    begin
        counter_next  = counter_reg;
        crc_next      = crc_reg;
        length_next   = length_reg;
        flags_next    = flags_reg;
        sequence_next = sequence_reg;
        sysid_next    = sysid_reg;
        compid_next   = compid_reg;
        msgid_next    = msgid_reg;
        rx_crc_next   = rx_crc_reg;
        done          = 1'b0;
        pvalid        = 1'b0;
        unique case (phase_reg)
            mav2fp_pkg::PH_IDLE:
                if (data_byte == mav2fp_pkg::START_MARKER)
                begin
                    counter_next = 8'd0;
                    crc_next     = mav2fp_pkg::CRC_SEED;
                    msgid_next   = 24'd0;
                end
            mav2fp_pkg::PH_LEN:
            begin
                length_next = data_byte;
                crc_next    = crc_upd;
            end
            mav2fp_pkg::PH_IFLAGS:
            begin
                flags_next = {flags_reg[15:8], data_byte};
                crc_next   = crc_upd;
            end
            mav2fp_pkg::PH_CFLAGS:
            begin
                flags_next = {data_byte, flags_reg[7:0]};
                crc_next   = crc_upd;
            end
            mav2fp_pkg::PH_SEQ:
            begin
                sequence_next = data_byte;
                crc_next      = crc_upd;
            end
            mav2fp_pkg::PH_SYS:
            begin
                sysid_next = data_byte;
                crc_next   = crc_upd;
            end
            mav2fp_pkg::PH_COMP:
            begin
                compid_next = data_byte;
                crc_next    = crc_upd;
            end
            mav2fp_pkg::PH_MID0:
            begin
                msgid_next = {msgid_reg[23:8], data_byte};
                crc_next   = crc_upd;
            end
            mav2fp_pkg::PH_MID1:
            begin
                msgid_next = {msgid_reg[23:16], data_byte, msgid_reg[7:0]};
                crc_next   = crc_upd;
            end
            mav2fp_pkg::PH_MID2:
            begin
                msgid_next   = {data_byte, msgid_reg[15:0]};
                crc_next     = crc_upd;
                counter_next = 8'd0;
            end
            mav2fp_pkg::PH_PAYLOAD:
            begin
                pvalid       = 1'b1;
                crc_next     = crc_upd;
                counter_next = (counter_inc >= length_reg) ? 8'd0 : counter_inc;
            end
            mav2fp_pkg::PH_CRC_LO:
                rx_crc_next = {rx_crc_reg[15:8], data_byte};
            mav2fp_pkg::PH_CRC_HI:
            begin
                rx_crc_next  = {data_byte, rx_crc_reg[7:0]};
                counter_next = 8'd0;
                done         = !flags_reg[0];
            end
            mav2fp_pkg::PH_SIG:
                if (counter_inc >= mav2fp_pkg::SIGNATURE_BYTES)
                begin
                    counter_next = 8'd0;
                    done         = 1'b1;
                end
                else
                begin
                    counter_next = counter_inc;
                end
            default:
            begin
                counter_next = counter_reg;
            end
        endcase
    end

    always_comb
    begin
        result.frame_done      = done;
        result.payload_valid   = pvalid;
        result.payload_byte    = pvalid ? data_byte : 8'd0;
        result.payload_index   = pvalid ? counter_reg : 8'd0;
        result.payload_length  = length_next;
        result.flag_bytes      = flags_next;
        result.sequence_number = sequence_next;
        result.system_id       = sysid_next;
        result.component_id    = compid_next;
        result.message_id      = msgid_next;
        result.crc_computed    = crc_next;
        result.crc_received    = rx_crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mav2fp_pkg::PH_IDLE;
            counter_reg  <= 8'd0;
            crc_reg      <= mav2fp_pkg::CRC_SEED;
            length_reg   <= 8'd0;
            flags_reg    <= 16'd0;
            sequence_reg <= 8'd0;
            sysid_reg    <= 8'd0;
            compid_reg   <= 8'd0;
            msgid_reg    <= 24'd0;
            rx_crc_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            counter_reg  <= counter_next;
            crc_reg      <= crc_next;
            length_reg   <= length_next;
            flags_reg    <= flags_next;
            sequence_reg <= sequence_next;
            sysid_reg    <= sysid_next;
            compid_reg   <= compid_next;
            msgid_reg    <= msgid_next;
            rx_crc_reg   <= rx_crc_next;
        end
    end

endmodule

// File: hdl/mavlink_v2_frame_parser_top.sv
// mavlink v2 frame parser
// input channel: one raw stream byte per transfer on data_byte, in_valid/in_stall
// output channel: exactly one result per input byte, out_valid/out_stall
// each result carries frame_done, payload_valid/byte/index and the current
// header, message id, computed crc and received crc views
// the result for a byte goes to the output register, or to the skid register while
// a stalled result waits; throughput: one byte per cycle while in_stall is low, set by
// a single state step and one crc byte update between input transfer and output register
// a two-entry output stage (output register plus skid register) lets a byte be
// taken while a result waits; in_stall rises only when both entries are full
// and comes from a register, so it never depends on out_stall in the same cycle
// a stalled result holds steady on the output ports until it is taken
// reset: parser returns to hunting the start marker, crc to 0xffff, captured
// fields to zero, and both output entries are emptied
module mavlink_v2_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_done,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic [7:0]  payload_length,
    output logic [15:0] flag_bytes,
    output logic [7:0]  sequence_number,
    output logic [7:0]  system_id,
    output logic [7:0]  component_id,
    output logic [23:0] message_id,
    output logic [15:0] crc_computed,
    output logic [15:0] crc_received
);

    mav2fp_pkg::result_t new_result;
    mav2fp_pkg::result_t out_data_reg;
    mav2fp_pkg::result_t skid_data_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic accept;
    logic out_take;

    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    mav2fp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .result    (new_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= new_result;
            end
            else
            begin
                out_data_reg <= new_result;
            end
        end
    end

    assign in_stall        = skid_valid_reg;
    assign out_valid       = out_valid_reg;
    assign frame_done      = out_data_reg.frame_done;
    assign payload_valid   = out_data_reg.payload_valid;
    assign payload_byte    = out_data_reg.payload_byte;
    assign payload_index   = out_data_reg.payload_index;
    assign payload_length  = out_data_reg.payload_length;
    assign flag_bytes      = out_data_reg.flag_bytes;
    assign sequence_number = out_data_reg.sequence_number;
    assign system_id       = out_data_reg.system_id;
    assign component_id    = out_data_reg.component_id;
    assign message_id      = out_data_reg.message_id;
    assign crc_computed    = out_data_reg.crc_computed;
    assign crc_received    = out_data_reg.crc_received;

endmodule

// File: hdl/mav2fp_checker.sv
module mav2fp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        frame_done,
    input logic        payload_valid,
    input logic [7:0]  payload_byte,
    input logic [7:0]  payload_index,
    input logic [7:0]  payload_length
);

    // a byte is never both payload and end of frame
    a_done_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_done && payload_valid))
        else $error("frame_done together with payload_valid");

    // payload index stays inside the captured length
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && payload_valid) |-> (payload_index < payload_length))
        else $error("payload_index beyond payload_length");

    // input side only stalls while a result is waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without a pending result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(payload_byte)
            && $stable(payload_index) && $stable(frame_done)))
        else $error("stalled result changed");

endmodule

bind mavlink_v2_frame_parser_top mav2fp_checker u_mav2fp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_done     (frame_done),
    .payload_valid  (payload_valid),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .payload_length (payload_length)
);
